### sv/mstd_pkg.sv
// Shared types and constants for the multi-slot deadline timer.
package mstd_pkg;

  localparam int SLOTS_DEF = 16;
  localparam int TIME_BITS_DEF = 32;

  localparam int SLOT_FIELD_W = 4;
  localparam int TIME_FIELD_W = 32;
  localparam int REM_W = 31;
  localparam int IN_TDATA_W = 40;
  localparam int OUT_TDATA_W = 40;

  localparam logic [31:0] UPD_INTERVAL_RST = 32'd1000;

  typedef enum logic [1:0] {
    OP_ARM   = 2'd0,
    OP_CLEAR = 2'd1,
    OP_TICK  = 2'd2,
    OP_NONE  = 2'd3
  } opcode_e;

  typedef enum logic {
    KIND_TIMEOUT = 1'b0,
    KIND_UPDATE  = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH
  } scan_state_e;

  typedef struct packed {
    logic rd_en;
    logic dl_we;
    logic lu_we;
  } mem_ctl_t;

endpackage

### sv/mstd_mem.sv
// Deadline and update-stamp memories with a registered read port.
module mstd_mem
  import mstd_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEF,
  parameter int TIME_BITS = TIME_BITS_DEF,
  localparam int SlotW = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  logic                 clk_i,
  input  mem_ctl_t             ctl_i,
  input  logic [SlotW-1:0]     rd_addr_i,
  input  logic [SlotW-1:0]     wr_addr_i,
  input  logic [TIME_BITS-1:0] wr_data_i,
  output logic [TIME_BITS-1:0] dl_rd_o,
  output logic [TIME_BITS-1:0] lu_rd_o
);

  logic [TIME_BITS-1:0] dl_mem [SLOTS];
  logic [TIME_BITS-1:0] lu_mem [SLOTS];

  always_ff @(posedge clk_i) begin
    if (ctl_i.dl_we) begin
      dl_mem[wr_addr_i] <= wr_data_i;
    end
    if (ctl_i.lu_we) begin
      lu_mem[wr_addr_i] <= wr_data_i;
    end
    if (ctl_i.rd_en) begin
      dl_rd_o <= dl_mem[rd_addr_i];
      lu_rd_o <= lu_mem[rd_addr_i];
    end
  end

endmodule

### sv/mstd_ctrl.sv
// Command decode, slot scan sequencer, event evaluation and output stage.
module mstd_ctrl
  import mstd_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEF,
  parameter int TIME_BITS = TIME_BITS_DEF,
  localparam int SlotW = (SLOTS > 1) ? $clog2(SLOTS) : 1,
  localparam int CmpW = (TIME_BITS > 32) ? TIME_BITS : 32
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [1:0]              in_op_i,
  input  logic [SLOT_FIELD_W-1:0] in_slot_i,
  input  logic [TIME_FIELD_W-1:0] in_time_i,
  input  logic [31:0]             interval_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [SLOT_FIELD_W-1:0] out_slot_o,
  output logic                    out_kind_o,
  output logic [REM_W-1:0]        out_rem_o,
  output logic                    out_last_o,
  output mem_ctl_t                mem_ctl_o,
  output logic [SlotW-1:0]        mem_rd_addr_o,
  output logic [SlotW-1:0]        mem_wr_addr_o,
  output logic [TIME_BITS-1:0]    mem_wr_data_o,
  input  logic [TIME_BITS-1:0]    dl_rd_i,
  input  logic [TIME_BITS-1:0]    lu_rd_i
);

  scan_state_e state_q, state_d;

  logic [SLOTS-1:0]        armed_q;
  logic [SLOTS-1:0]        stamped_q;
  logic [SlotW-1:0]        idx_q;
  logic [TIME_BITS-1:0]    now_q;

  logic                    pend_v_q;
  logic [SLOT_FIELD_W-1:0] pend_slot_q;
  logic                    pend_kind_q;
  logic [REM_W-1:0]        pend_rem_q;

  logic                    out_v_q;
  logic [SLOT_FIELD_W-1:0] out_slot_q;
  logic                    out_kind_q;
  logic [REM_W-1:0]        out_rem_q;
  logic                    out_last_q;

  logic                    accept;
  logic                    is_tick;
  logic [SlotW-1:0]        in_idx;
  logic [TIME_BITS-1:0]    in_t;
  logic                    in_ok;

  logic                    cur_armed;
  logic                    cur_stamped;
  logic [TIME_BITS-1:0]    rem;
  logic [TIME_BITS-1:0]    elapsed;
  logic [CmpW-1:0]         rem_x;
  logic                    expire;
  logic                    upd;
  logic                    ev;
  logic [REM_W-1:0]        ev_rem;
  logic                    push_room;
  logic                    stall;
  logic                    step;
  logic                    last_idx;
  logic                    flush_go;
  logic                    load_out;

  assign in_idx = SlotW'(in_slot_i);
  assign in_t   = TIME_BITS'(in_time_i);
  assign in_ok  = 32'(in_slot_i) < SLOTS;
  assign accept = in_valid_i && in_ready_o;
  assign is_tick = (in_op_i == OP_TICK);

  // Evaluation of the slot whose memory word arrived this cycle.
  assign cur_armed   = armed_q[idx_q];
  assign cur_stamped = stamped_q[idx_q];
  assign rem         = dl_rd_i - now_q;
  assign elapsed     = now_q - lu_rd_i;
  assign rem_x       = CmpW'(rem);
  assign expire      = (rem == '0) || rem[TIME_BITS-1];
  assign upd         = !expire && (!cur_stamped ||
                       (!elapsed[TIME_BITS-1] && (CmpW'(elapsed) >= CmpW'(interval_i))));
  assign ev          = (state_q == ST_SCAN) && cur_armed && (expire || upd);
  assign ev_rem      = expire ? '0 : ((|rem_x[CmpW-1:REM_W]) ? '1 : rem_x[REM_W-1:0]);

  assign push_room = !out_v_q || out_ready_i;
  assign stall     = ev && pend_v_q && !push_room;
  assign step      = (state_q == ST_SCAN) && !stall;
  assign last_idx  = (idx_q == SlotW'(SLOTS - 1));
  assign flush_go  = (state_q == ST_FLUSH) && (!pend_v_q || push_room);
  assign load_out  = (step && ev && pend_v_q) || (flush_go && pend_v_q);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && is_tick) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (step && last_idx) begin
          state_d = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (flush_go) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o      = (state_q == ST_IDLE);
    mem_ctl_o.rd_en = (accept && is_tick) || (step && !last_idx);
    mem_ctl_o.dl_we = accept && (in_op_i == OP_ARM) && in_ok;
    mem_ctl_o.lu_we = step && cur_armed && upd;
    mem_rd_addr_o   = (state_q == ST_IDLE) ? '0 : idx_q + 1'b1;
    mem_wr_addr_o   = (state_q == ST_IDLE) ? in_idx : idx_q;
    mem_wr_data_o   = (state_q == ST_IDLE) ? in_t : now_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      armed_q   <= '0;
      stamped_q <= '0;
      pend_v_q  <= 1'b0;
      out_v_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (accept && in_ok && (in_op_i == OP_ARM)) begin
        armed_q[in_idx] <= 1'b1;
      end
      if (accept && in_ok && (in_op_i == OP_CLEAR)) begin
        armed_q[in_idx]   <= 1'b0;
        stamped_q[in_idx] <= 1'b0;
      end
      if (step && cur_armed) begin
        if (expire) begin
          armed_q[idx_q]   <= 1'b0;
          stamped_q[idx_q] <= 1'b0;
        end else if (upd) begin
          stamped_q[idx_q] <= 1'b1;
        end
      end
      if (step && ev) begin
        pend_v_q <= 1'b1;
      end else if (flush_go) begin
        pend_v_q <= 1'b0;
      end
      if (load_out) begin
        out_v_q <= 1'b1;
      end else if (out_ready_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && is_tick) begin
      now_q <= in_t;
      idx_q <= '0;
    end else if (step && !last_idx) begin
      idx_q <= idx_q + 1'b1;
    end
    if (step && ev) begin
      pend_slot_q <= SLOT_FIELD_W'(idx_q);
      pend_kind_q <= expire ? KIND_TIMEOUT : KIND_UPDATE;
      pend_rem_q  <= ev_rem;
    end
    if (load_out) begin
      out_slot_q <= pend_slot_q;
      out_kind_q <= pend_kind_q;
      out_rem_q  <= pend_rem_q;
      out_last_q <= (state_q == ST_FLUSH);
    end
  end

  assign out_valid_o = out_v_q;
  assign out_slot_o  = out_slot_q;
  assign out_kind_o  = out_kind_q;
  assign out_rem_o   = out_rem_q;
  assign out_last_o  = out_last_q;

endmodule

### sv/multi_slot_deadline_timer_core.sv
// Top level of the multi-slot deadline timer: ports, interval register and assertions.
//
// Channel   Direction  Beat carries
// s_axis    in         tuser opcode; tdata slot, time value
// m_axis    out        tuser event kind; tdata slot, remaining ms; tlast last event of tick
// cfg       in         update interval
//
// An arm or clear beat is handled in its accept cycle. A tick is accepted, then the scan
// walks the deadline memory slot by slot through its one read port, and a final flush state
// releases the held last event; m_axis stalls can hold both the scan and the flush.
// Reset clears the armed and stamped flags; the memories need no clearing pass.
// A new s_axis beat is taken only once the previous tick has handed off its last event.
module multi_slot_deadline_timer_core
  import mstd_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEF,
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // slot [3:0], time_value [35:4]
  input  logic [1:0]             s_axis_tuser,  // opcode [1:0]
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // event_slot [3:0], remaining_ms [34:4]
  output logic                   m_axis_tuser,  // event_kind [0]
  output logic                   m_axis_tlast,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [31:0]            cfg_data_i
);

  localparam int SlotW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  logic [31:0]             interval_q;
  mem_ctl_t                mem_ctl;
  logic [SlotW-1:0]        mem_rd_addr;
  logic [SlotW-1:0]        mem_wr_addr;
  logic [TIME_BITS-1:0]    mem_wr_data;
  logic [TIME_BITS-1:0]    dl_rd;
  logic [TIME_BITS-1:0]    lu_rd;
  logic [SLOT_FIELD_W-1:0] out_slot;
  logic [REM_W-1:0]        out_rem;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interval_q <= UPD_INTERVAL_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      interval_q <= cfg_data_i;
    end
  end

  mstd_ctrl #(
    .SLOTS     (SLOTS),
    .TIME_BITS (TIME_BITS)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .in_op_i       (s_axis_tuser),
    .in_slot_i     (s_axis_tdata[SLOT_FIELD_W-1:0]),
    .in_time_i     (s_axis_tdata[SLOT_FIELD_W+TIME_FIELD_W-1:SLOT_FIELD_W]),
    .interval_i    (interval_q),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_slot_o    (out_slot),
    .out_kind_o    (m_axis_tuser),
    .out_rem_o     (out_rem),
    .out_last_o    (m_axis_tlast),
    .mem_ctl_o     (mem_ctl),
    .mem_rd_addr_o (mem_rd_addr),
    .mem_wr_addr_o (mem_wr_addr),
    .mem_wr_data_o (mem_wr_data),
    .dl_rd_i       (dl_rd),
    .lu_rd_i       (lu_rd)
  );

  mstd_mem #(
    .SLOTS     (SLOTS),
    .TIME_BITS (TIME_BITS)
  ) u_mem (
    .clk_i     (clk_i),
    .ctl_i     (mem_ctl),
    .rd_addr_i (mem_rd_addr),
    .wr_addr_i (mem_wr_addr),
    .wr_data_i (mem_wr_data),
    .dl_rd_o   (dl_rd),
    .lu_rd_o   (lu_rd)
  );

  assign m_axis_tdata = {
    {(OUT_TDATA_W - SLOT_FIELD_W - REM_W){1'b0}}, out_rem, out_slot
  };

  a_tick_blocks_input : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && (s_axis_tuser == OP_TICK)) |=> !s_axis_tready)
    else $error("input still ready after a tick beat");

  a_cmd_keeps_ready : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && (s_axis_tuser != OP_TICK)) |=> s_axis_tready)
    else $error("arm or clear beat blocked the input");

  a_timeout_zero_rem : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser == KIND_TIMEOUT)) |-> (out_rem == '0))
    else $error("timeout beat carries a nonzero remaining time");

endmodule
